FILE: hw/rtl/saia_pkg.sv
// saia_pkg: opcodes, widths and handshake structs for the shift-add integer ALU.
// No dependencies; used by saia_core and shift_add_integer_alu.
package saia_pkg;

	localparam int WORD_W = 64;
	localparam int CNT_W  = 6;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} saia_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} saia_sts_t;

endpackage

FILE: hw/rtl/shift_add_integer_alu.sv
// shift_add_integer_alu: add, subtract and multiply run over the full word, divide over
// DIV_BITS bits, on the one-bit-per-cycle datapath in saia_core; the core's result is then
// registered into the output register that drives rsp_valid, once that register is free.
// A finished word waits in the output register while the next one is computed.
// arst_n clears the handshake state; no data is reset. Depends on saia_pkg, saia_core.
module shift_add_integer_alu #(
	parameter int DIV_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  opcode,
	input  logic signed [63:0]          operand_a,
	input  logic signed [63:0]          operand_b,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic signed [63:0]          result
);

	saia_pkg::saia_ctl_t         ctl;
	saia_pkg::saia_sts_t         sts;
	logic [saia_pkg::WORD_W-1:0] acc;
	logic                        busy_q;
	logic                        rsp_valid_q;
	logic [saia_pkg::WORD_W-1:0] result_q;
	logic                        move;

	assign req_ready = ~busy_q;
	assign ctl.start = req_valid & req_ready;
	assign ctl.op    = saia_pkg::op_t'(opcode);
	assign move      = busy_q & sts.done & ~sts.busy & (~rsp_valid_q | rsp_ready);

	saia_core #(
		.DIV_BITS(DIV_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a      (operand_a),
		.b      (operand_b),
		.sts    (sts),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			result_q <= acc;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;

endmodule

FILE: hw/rtl/saia_core.sv
// saia_core: one-bit-per-cycle datapath. Serial add/subtract, shift-add multiply,
// restoring divide. Depends on saia_pkg.
module saia_core #(
	parameter int DIV_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  saia_pkg::saia_ctl_t         ctl,
	input  logic [saia_pkg::WORD_W-1:0] a,
	input  logic [saia_pkg::WORD_W-1:0] b,
	output saia_pkg::saia_sts_t         sts,
	output logic [saia_pkg::WORD_W-1:0] acc
);

	logic [saia_pkg::WORD_W-1:0] a_q;
	logic [saia_pkg::WORD_W-1:0] b_q;
	logic [saia_pkg::WORD_W-1:0] acc_q;
	logic [DIV_BITS-1:0]         rem_q;
	logic [saia_pkg::CNT_W-1:0]  cnt_q;
	saia_pkg::op_t               op_q;
	logic                        carry_q;
	logic                        busy_q;
	logic                        done_q;

	logic                        bx;
	logic                        sbit;
	logic                        cout;
	logic [DIV_BITS:0]           rem_sh;
	logic [DIV_BITS+1:0]         diff;
	logic                        qbit;

	// serial adder bit
	assign bx   = b_q[0] ^ (op_q == saia_pkg::OP_SUB);
	assign sbit = a_q[0] ^ bx ^ carry_q;
	assign cout = (a_q[0] & bx) | (a_q[0] & carry_q) | (bx & carry_q);

	// restoring divide trial subtract
	assign rem_sh = {rem_q, a_q[DIV_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, b_q[DIV_BITS-1:0]};
	assign qbit   = ~diff[DIV_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			if (ctl.op == saia_pkg::OP_DIV) begin
				cnt_q <= saia_pkg::CNT_W'(DIV_BITS - 1);
			end else begin
				cnt_q <= saia_pkg::CNT_W'(saia_pkg::WORD_W - 1);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q     <= a;
			b_q     <= b;
			acc_q   <= '0;
			rem_q   <= '0;
			op_q    <= ctl.op;
			carry_q <= (ctl.op == saia_pkg::OP_SUB);
		end else if (busy_q) begin
			case (op_q)
				saia_pkg::OP_ADD, saia_pkg::OP_SUB: begin
					acc_q   <= {sbit, acc_q[saia_pkg::WORD_W-1:1]};
					a_q     <= {1'b0, a_q[saia_pkg::WORD_W-1:1]};
					b_q     <= {1'b0, b_q[saia_pkg::WORD_W-1:1]};
					carry_q <= cout;
				end
				saia_pkg::OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= {a_q[saia_pkg::WORD_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[saia_pkg::WORD_W-1:1]};
				end
				default: begin
					if (qbit) begin
						rem_q <= diff[DIV_BITS-1:0];
					end else begin
						rem_q <= rem_sh[DIV_BITS-1:0];
					end
					acc_q <= {acc_q[saia_pkg::WORD_W-2:0], qbit};
					a_q   <= {a_q[saia_pkg::WORD_W-2:0], 1'b0};
				end
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;

endmodule

FILE: hw/rtl/saia_checker.sv
// saia_checker: port-level assertions for shift_add_integer_alu, bound to the top.
// Depends on nothing but the top level's ports.
module saia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] result
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after accepting a word");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response appeared one cycle after accept");

	a_ready_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_ready) |-> rsp_valid)
		else $error("unit freed without presenting a word");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result))
		else $error("stalled response changed");

endmodule

bind shift_add_integer_alu saia_checker u_saia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.result    (result)
);
